### rtl/tle_pkg.sv
// ----------------------------------------------------------------------------
// tle_pkg
// Shared types and constants of the terminal line editor: character codes,
// command kinds passed from the front end to the back end, queue sizing.
// ----------------------------------------------------------------------------
package tle_pkg;

  localparam int LINE_BYTES = 256;
  localparam int CAP_INT    = (LINE_BYTES - 1 < 255) ? LINE_BYTES - 1 : 255;
  localparam logic [7:0] LIMIT_CAP   = 8'(CAP_INT);
  localparam logic [7:0] LIMIT_RESET = 8'd255;

  localparam logic [7:0] CH_BS  = 8'd8;
  localparam logic [7:0] CH_LF  = 8'd10;
  localparam logic [7:0] CH_CR  = 8'd13;
  localparam logic [7:0] CH_SP  = 8'd32;
  localparam logic [7:0] CH_NUL = 8'd0;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  typedef enum logic [1:0] {
    CMD_BS   = 2'd0,
    CMD_CR   = 2'd1,
    CMD_CHAR = 2'd2,
    CMD_LF   = 2'd3
  } tle_kind_t;

  typedef struct packed {
    tle_kind_t  kind;
    logic [7:0] ch;
    logic [7:0] pos;
  } tle_cmd_t;

  // head of queue as seen by the back end
  typedef struct packed {
    logic     valid;
    tle_cmd_t cmd;
  } tle_head_t;

endpackage

### rtl/tle_front.sv
// ----------------------------------------------------------------------------
// tle_front
// Accepts received bytes, keeps the line write position and the line limit,
// classifies each byte and hands a command to the queue.
// ----------------------------------------------------------------------------
module tle_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,
  input  logic              cfg_tvalid,
  output logic              cfg_tready,
  input  logic [7:0]        cfg_tdata,
  input  logic              q_full,
  output logic              q_push,
  output tle_pkg::tle_cmd_t q_cmd
);

  logic [7:0] pos_r, pos_nxt;
  logic [7:0] limit_r, limit_nxt;
  logic [7:0] eff_limit;
  logic       take;
  logic       keep;

  assign in_tready  = !q_full;
  assign cfg_tready = 1'b1;
  assign take       = in_tvalid && in_tready;
  assign eff_limit  = (limit_r < tle_pkg::LIMIT_CAP) ? limit_r : tle_pkg::LIMIT_CAP;

  always_comb begin
    keep    = 1'b0;
    pos_nxt = pos_r;
    q_cmd.kind = tle_pkg::CMD_CHAR;
    q_cmd.ch   = in_tdata;
    q_cmd.pos  = pos_r;
    priority if (in_tdata == tle_pkg::CH_BS) begin
      q_cmd.kind = tle_pkg::CMD_BS;
      keep       = (pos_r != 8'd0);
      pos_nxt    = pos_r - 8'd1;
    end else if (in_tdata == tle_pkg::CH_CR) begin
      q_cmd.kind = tle_pkg::CMD_CR;
      keep       = 1'b1;
      pos_nxt    = 8'd0;
    end else begin
      q_cmd.kind = (in_tdata == tle_pkg::CH_LF) ? tle_pkg::CMD_LF : tle_pkg::CMD_CHAR;
      // bytes past the limit are dropped silently
      keep       = (pos_r < eff_limit);
      pos_nxt    = pos_r + 8'd1;
    end
  end

  assign q_push    = take && keep;
  assign limit_nxt = (cfg_tvalid && cfg_tready) ? cfg_tdata : limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= 8'd0;
      limit_r <= tle_pkg::LIMIT_RESET;
    end else begin
      limit_r <= limit_nxt;
      if (q_push) begin
        pos_r <= pos_nxt;
      end
    end
  end

endmodule

### rtl/tle_queue.sv
// ----------------------------------------------------------------------------
// tle_queue
// Short command queue between front end and back end.
// ----------------------------------------------------------------------------
module tle_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  tle_pkg::tle_cmd_t  push_cmd,
  output logic               full,
  input  logic               pop,
  output tle_pkg::tle_head_t head
);

  tle_pkg::tle_cmd_t         slot_r [tle_pkg::QDEPTH];
  logic [tle_pkg::QAW-1:0]   wr_r, wr_nxt;
  logic [tle_pkg::QAW-1:0]   rd_r, rd_nxt;
  logic [tle_pkg::QAW:0]     cnt_r, cnt_nxt;
  logic                      do_push;
  logic                      do_pop;

  assign full       = (cnt_r == (tle_pkg::QAW+1)'(tle_pkg::QDEPTH));
  assign head.valid = (cnt_r != '0);
  assign head.cmd   = slot_r[rd_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head.valid;

  always_comb begin
    wr_nxt  = do_push ? wr_r + (tle_pkg::QAW)'(1) : wr_r;
    rd_nxt  = do_pop ? rd_r + (tle_pkg::QAW)'(1) : rd_r;
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + (tle_pkg::QAW+1)'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - (tle_pkg::QAW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

### rtl/tle_back.sv
// ----------------------------------------------------------------------------
// tle_back
// Expands each queued command into its echo / store / line-done results,
// one result per cycle unless stalled, into a registered output stage.
// ----------------------------------------------------------------------------
module tle_back (
  input  logic               clk,
  input  logic               rst_n,
  input  tle_pkg::tle_head_t head,
  output logic               pop,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [31:0]        out_tdata,
  output logic [2:0]         out_tuser,
  output logic               out_tlast
);

  logic [1:0]  beat_r, beat_nxt;
  logic        vld_r, vld_nxt;
  logic [31:0] data_r;
  logic [2:0]  user_r;
  logic        last_r;
  logic        load;

  logic [7:0]  echo_b, st_idx, st_b, len_b;
  logic        st_v, done_v, last_b;

  always_comb begin
    echo_b = head.cmd.ch;
    st_v   = 1'b0;
    st_idx = 8'd0;
    st_b   = 8'd0;
    done_v = 1'b0;
    len_b  = 8'd0;
    last_b = 1'b0;
    unique case (head.cmd.kind)
      tle_pkg::CMD_BS: begin
        echo_b = (beat_r == 2'd1) ? tle_pkg::CH_SP : tle_pkg::CH_BS;
        last_b = (beat_r == 2'd2);
      end
      tle_pkg::CMD_CR: begin
        if (beat_r == 2'd0) begin
          echo_b = tle_pkg::CH_LF;
          st_v   = 1'b1;
          st_idx = head.cmd.pos;
          st_b   = tle_pkg::CH_NUL;
        end else begin
          echo_b = tle_pkg::CH_CR;
          done_v = 1'b1;
          len_b  = head.cmd.pos;
          last_b = 1'b1;
        end
      end
      tle_pkg::CMD_CHAR: begin
        st_v   = 1'b1;
        st_idx = head.cmd.pos;
        st_b   = head.cmd.ch;
        last_b = 1'b1;
      end
      tle_pkg::CMD_LF: begin
        if (beat_r == 2'd0) begin
          st_v   = 1'b1;
          st_idx = head.cmd.pos;
          st_b   = head.cmd.ch;
        end else begin
          echo_b = tle_pkg::CH_CR;
          last_b = 1'b1;
        end
      end
      default: begin
        last_b = 1'b1;
      end
    endcase
  end

  // output register frees up when empty or being taken
  assign load = head.valid && (!vld_r || out_tready);
  assign pop  = load && last_b;

  always_comb begin
    beat_nxt = beat_r;
    if (load) begin
      beat_nxt = last_b ? 2'd0 : beat_r + 2'd1;
    end
    vld_nxt = vld_r;
    if (load) begin
      vld_nxt = 1'b1;
    end else if (out_tready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= {len_b, st_b, st_idx, echo_b};
      user_r <= {done_v, st_v, 1'b1};
      last_r <= last_b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_r <= 2'd0;
      vld_r  <= 1'b0;
    end else begin
      beat_r <= beat_nxt;
      vld_r  <= vld_nxt;
    end
  end

  assign out_tvalid = vld_r;
  assign out_tdata  = data_r;
  assign out_tuser  = user_r;
  assign out_tlast  = last_r;

endmodule

### rtl/terminal_line_editor_with_echo.sv
// ----------------------------------------------------------------------------
// terminal_line_editor_with_echo
// Canonical-mode line editor: stores typed bytes, handles backspace and
// return, and produces the echo stream for the terminal.
//
//   channel  | dir | tdata                        | tuser / tlast
//   in_      | in  | [7:0] rx_byte                | -
//   out_     | out | [7:0] echo_byte,            | tuser[0] echo_valid,
//            |     | [15:8] store_index,          | [1] store_valid,
//            |     | [23:16] store_byte,          | [2] line_done;
//            |     | [31:24] line_length          | tlast = last of request
//   cfg_     | in  | [7:0] line_limit             | -
//
// The front end takes one request per cycle while the 4-entry command queue
// has room; the back end emits one result per cycle while the output is not
// stalled, and a request yields 1 (plain byte), 2 (return, line feed) or 3
// (backspace) results. Requests that produce nothing (backspace on an empty
// line, byte past the limit) are consumed but never reach the queue.
// Reset clears the position, the queue and the output stage; the limit
// resets to 255. A stalled output holds its result and backs up the queue.
// ----------------------------------------------------------------------------
module terminal_line_editor_with_echo (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,   // echo_byte, store_index, store_byte, line_length
  output logic [2:0]  out_tuser,   // echo_valid, store_valid, line_done
  output logic        out_tlast,
  input  logic        cfg_tvalid,
  output logic        cfg_tready,
  input  logic [7:0]  cfg_tdata    // [7:0] line_limit
);

  logic               q_full;
  logic               q_push;
  logic               q_pop;
  tle_pkg::tle_cmd_t  q_cmd;
  tle_pkg::tle_head_t q_head;

  tle_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .cfg_tvalid (cfg_tvalid),
    .cfg_tready (cfg_tready),
    .cfg_tdata  (cfg_tdata),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_cmd      (q_cmd)
  );

  tle_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .head     (q_head)
  );

  tle_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (q_head),
    .pop        (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
